// ----- hw/rtl/fdbm_pkg.sv -----
// Shared constants, register indexes and types of the frame difference motion core.
package fdbm_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 512;
  localparam int DEF_BLOCK_W    = 5;
  localparam int DEF_BLOCK_H    = 5;

  localparam int CHAN_W      = 8;
  localparam int PIX_W       = 3 * CHAN_W;
  localparam int FW_W        = 11;
  localparam int FH_W        = 10;
  localparam int PTHR_W      = 8;
  localparam int BTHR_W      = 5;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 11;
  localparam int PIX_TOT_W   = 20;
  localparam int BLK_TOT_W   = 15;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 40;

  localparam logic [FW_W-1:0]   RST_FRAME_WIDTH  = 11'd640;
  localparam logic [FH_W-1:0]   RST_FRAME_HEIGHT = 10'd480;
  localparam logic [PTHR_W-1:0] RST_PIX_THR      = 8'd10;
  localparam logic [BTHR_W-1:0] RST_BLK_THR      = 5'd20;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PIX_THR      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLK_THR      = 3'd3;

  localparam logic [PIX_TOT_W-1:0] PIX_TOT_MAX = '1;
  localparam logic [BLK_TOT_W-1:0] BLK_TOT_MAX = '1;

  // Position flags of one pixel, handed from the raster tracker to the datapath.
  typedef struct packed {
    logic blk_close;
    logic frame_end;
  } rast_t;

endpackage

// ----- hw/rtl/fdbm_raster.sv -----
// Raster position tracker: pixel column and row, block column, block-close and frame-end flags.
module fdbm_raster import fdbm_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int BLOCK_W    = DEF_BLOCK_W,
  parameter int BLOCK_H    = DEF_BLOCK_H,
  localparam int CW    = $clog2(MAX_WIDTH),
  localparam int RW    = $clog2(MAX_HEIGHT),
  localparam int BCOLS = (MAX_WIDTH + BLOCK_W - 1) / BLOCK_W,
  localparam int BCW   = (BCOLS > 1) ? $clog2(BCOLS) : 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  logic [FW_W-1:0] frame_width,
  input  logic [FH_W-1:0] frame_height,
  output logic [CW-1:0]   col,
  output logic [RW-1:0]   row,
  output logic [BCW-1:0]  bcol,
  output rast_t           flags
);

  localparam int BXW = (BLOCK_W > 1) ? $clog2(BLOCK_W) : 1;
  localparam int BYW = (BLOCK_H > 1) ? $clog2(BLOCK_H) : 1;

  logic [CW-1:0]  col_r, col_nxt, w_m1;
  logic [RW-1:0]  row_r, row_nxt, h_m1;
  logic [BXW-1:0] bx_r, bx_nxt;
  logic [BYW-1:0] by_r, by_nxt;
  logic [BCW-1:0] bcol_r, bcol_nxt;
  logic           last_col, last_row, bx_end, by_end;

  // Sizes out of range are pulled into 1..MAX.
  always_comb begin
    if (frame_width == '0) begin
      w_m1 = '0;
    end else if (32'(frame_width) > 32'(MAX_WIDTH)) begin
      w_m1 = CW'(MAX_WIDTH - 1);
    end else begin
      w_m1 = CW'(frame_width - 11'd1);
    end
    if (frame_height == '0) begin
      h_m1 = '0;
    end else if (32'(frame_height) > 32'(MAX_HEIGHT)) begin
      h_m1 = RW'(MAX_HEIGHT - 1);
    end else begin
      h_m1 = RW'(frame_height - 10'd1);
    end
  end

  assign last_col = (col_r >= w_m1);
  assign last_row = (row_r >= h_m1);
  assign bx_end   = (bx_r == BXW'(BLOCK_W - 1));
  assign by_end   = (by_r == BYW'(BLOCK_H - 1));

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    bx_nxt   = bx_r;
    by_nxt   = by_r;
    bcol_nxt = bcol_r;
    if (last_col) begin
      col_nxt  = '0;
      bx_nxt   = '0;
      bcol_nxt = '0;
      if (last_row) begin
        row_nxt = '0;
        by_nxt  = '0;
      end else begin
        row_nxt = row_r + RW'(1);
        by_nxt  = by_end ? '0 : by_r + BYW'(1);
      end
    end else begin
      col_nxt = col_r + CW'(1);
      if (bx_end) begin
        bx_nxt   = '0;
        bcol_nxt = bcol_r + BCW'(1);
      end else begin
        bx_nxt = bx_r + BXW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      bx_r   <= '0;
      by_r   <= '0;
      bcol_r <= '0;
    end else if (adv) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      bx_r   <= bx_nxt;
      by_r   <= by_nxt;
      bcol_r <= bcol_nxt;
    end
  end

  assign col             = col_r;
  assign row             = row_r;
  assign bcol            = bcol_r;
  assign flags.blk_close = (last_col || bx_end) && (last_row || by_end);
  assign flags.frame_end = last_col && last_row;

endmodule

// ----- hw/rtl/fdbm_frame_store.sv -----
// Frame store: previous frame pixels, read and overwritten by the same item.
module fdbm_frame_store import fdbm_pkg::*; #(
  parameter int AW = 19
) (
  input  logic             clk,
  input  logic             en,
  input  logic [AW-1:0]    addr,
  input  logic [PIX_W-1:0] wdata,
  output logic [PIX_W-1:0] rdata
);

  logic [PIX_W-1:0] store_r [2**AW];
  logic [PIX_W-1:0] rdata_r;

  // Read before write: the item sees the pixel left by the previous frame.
  always_ff @(posedge clk) begin
    if (en) begin
      rdata_r       <= store_r[addr];
      store_r[addr] <= wdata;
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/fdbm_blk_cnt.sv -----
// Block counter memory with per-entry valid bits and write-to-read forwarding.
module fdbm_blk_cnt import fdbm_pkg::*; #(
  parameter int BCOLS = 205,
  parameter int CNTW  = 6,
  localparam int BCW  = (BCOLS > 1) ? $clog2(BCOLS) : 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            rd_en,
  input  logic [BCW-1:0]  rd_idx,
  input  logic            wr_en,
  input  logic [BCW-1:0]  wr_idx,
  input  logic [CNTW-1:0] wr_val,
  output logic [CNTW-1:0] rd_val
);

  logic [CNTW-1:0]  cnt_mem_r [BCOLS];
  logic [BCOLS-1:0] vld_r;
  logic [CNTW-1:0]  rd_data_r, fwd_val_r;
  logic             rd_vld_r, fwd_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= cnt_mem_r[rd_idx];
      fwd_val_r <= wr_val;
    end
    if (wr_en) begin
      cnt_mem_r[wr_idx] <= wr_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
      fwd_r    <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_idx];
        // A write to the same entry in the read cycle is not seen by the memory read.
        fwd_r    <= wr_en && (wr_idx == rd_idx);
      end
      if (wr_en) begin
        vld_r[wr_idx] <= 1'b1;
      end
    end
  end

  assign rd_val = fwd_r ? fwd_val_r : (rd_vld_r ? rd_data_r : '0);

endmodule

// ----- hw/rtl/frame_difference_block_motion_core.sv -----
// Top level of the frame difference block motion core.
// Each item passes the frame store read and compare stage, then the output register.
// Throughput: one item per cycle unless the output stalls; the frame store takes one access
// per item, the block counter a read and a write; back-to-back counter hits are forwarded.
// Reset clears position, totals, counter valid bits and the primed flag; the frame store
// is not cleared, and the first frame after reset only fills it.
module frame_difference_block_motion_core import fdbm_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int BLOCK_W    = DEF_BLOCK_W,
  parameter int BLOCK_H    = DEF_BLOCK_H
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Input item. in_tdata: chan_a [7:0], chan_b [15:8], chan_c [23:16].
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // Result item. out_tdata: changed [0], changed_pixels [20:1], moving_blocks [35:21],
  // zeros above. out_tlast: frame_done.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast,
  // Configuration writes.
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int BCOLS = (MAX_WIDTH + BLOCK_W - 1) / BLOCK_W;
  localparam int BCW   = (BCOLS > 1) ? $clog2(BCOLS) : 1;
  localparam int CNT0  = $clog2(BLOCK_W * BLOCK_H + 1);
  // Counters saturate; one bit above the threshold width keeps the compare exact.
  localparam int CNTW  = (CNT0 > BTHR_W) ? CNT0 : BTHR_W + 1;

  // Configuration registers. Writes are taken at any time; indexes past the list are ignored.
  logic [FW_W-1:0]   frame_width_r;
  logic [FH_W-1:0]   frame_height_r;
  logic [PTHR_W-1:0] pix_thr_r;
  logic [BTHR_W-1:0] blk_thr_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= RST_FRAME_WIDTH;
      frame_height_r <= RST_FRAME_HEIGHT;
      pix_thr_r      <= RST_PIX_THR;
      blk_thr_r      <= RST_BLK_THR;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_data[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= cfg_data[FH_W-1:0];
        REG_PIX_THR:      pix_thr_r      <= cfg_data[PTHR_W-1:0];
        REG_BLK_THR:      blk_thr_r      <= cfg_data[BTHR_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake. The compare stage moves on whenever the output register is free or
  // being drained, and a new item enters when the compare stage moves or is empty.
  logic s1_valid_r, s1_fire, in_fire;
  logic out_valid_r;

  assign s1_fire   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_fire;
  assign in_fire   = in_tvalid && in_tready;

  // Stage 0: position and memory reads.
  logic [CW-1:0]  col;
  logic [RW-1:0]  row;
  logic [BCW-1:0] bcol;
  rast_t          flags;

  fdbm_raster #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .BLOCK_W   (BLOCK_W),
    .BLOCK_H   (BLOCK_H)
  ) u_raster (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (in_fire),
    .frame_width (frame_width_r),
    .frame_height(frame_height_r),
    .col         (col),
    .row         (row),
    .bcol        (bcol),
    .flags       (flags)
  );

  logic [PIX_W-1:0] old_pix;

  fdbm_frame_store #(
    .AW(RW + CW)
  ) u_store (
    .clk  (clk),
    .en   (in_fire),
    .addr ({row, col}),
    .wdata(in_tdata[PIX_W-1:0]),
    .rdata(old_pix)
  );

  logic [BCW-1:0]  s1_bcol_r;
  logic [CNTW-1:0] cnt_base, cnt_inc, cnt_wr;

  fdbm_blk_cnt #(
    .BCOLS(BCOLS),
    .CNTW (CNTW)
  ) u_blk_cnt (
    .clk   (clk),
    .rst_n (rst_n),
    .rd_en (in_fire),
    .rd_idx(bcol),
    .wr_en (s1_fire),
    .wr_idx(s1_bcol_r),
    .wr_val(cnt_wr),
    .rd_val(cnt_base)
  );

  // Stage 1: compare against the stored pixel, update block counter and totals.
  logic [PIX_W-1:0] s1_pix_r;
  rast_t            s1_flags_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pix_r   <= in_tdata[PIX_W-1:0];
      s1_bcol_r  <= bcol;
      s1_flags_r <= flags;
    end
  end

  logic [CHAN_W-1:0] diff_a, diff_b, diff_c;
  logic [CHAN_W-1:0] new_a, new_b, new_c, old_a, old_b, old_c;
  logic              changed, blk_hit;
  logic              primed_r;

  assign new_a = s1_pix_r[CHAN_W-1:0];
  assign new_b = s1_pix_r[2*CHAN_W-1:CHAN_W];
  assign new_c = s1_pix_r[3*CHAN_W-1:2*CHAN_W];
  assign old_a = old_pix[CHAN_W-1:0];
  assign old_b = old_pix[2*CHAN_W-1:CHAN_W];
  assign old_c = old_pix[3*CHAN_W-1:2*CHAN_W];
  assign diff_a = (new_a > old_a) ? new_a - old_a : old_a - new_a;
  assign diff_b = (new_b > old_b) ? new_b - old_b : old_b - new_b;
  assign diff_c = (new_c > old_c) ? new_c - old_c : old_c - new_c;

  // Before the store holds a whole frame no pixel counts as changed.
  assign changed = primed_r && (diff_a > pix_thr_r) && (diff_b > pix_thr_r) &&
                   (diff_c > pix_thr_r);

  assign cnt_inc = (changed && (cnt_base != '1)) ? cnt_base + CNTW'(1) : cnt_base;
  assign cnt_wr  = s1_flags_r.blk_close ? '0 : cnt_inc;
  assign blk_hit = s1_flags_r.blk_close && (cnt_inc > CNTW'(blk_thr_r));

  logic [PIX_TOT_W-1:0] pix_tot_r, pix_tot_nxt;
  logic [BLK_TOT_W-1:0] blk_tot_r, blk_tot_nxt;

  assign pix_tot_nxt = (changed && (pix_tot_r != PIX_TOT_MAX)) ?
                       pix_tot_r + PIX_TOT_W'(1) : pix_tot_r;
  assign blk_tot_nxt = (blk_hit && (blk_tot_r != BLK_TOT_MAX)) ?
                       blk_tot_r + BLK_TOT_W'(1) : blk_tot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_tot_r <= '0;
      blk_tot_r <= '0;
      primed_r  <= 1'b0;
    end else if (s1_fire) begin
      if (s1_flags_r.frame_end) begin
        pix_tot_r <= '0;
        blk_tot_r <= '0;
        primed_r  <= 1'b1;
      end else begin
        pix_tot_r <= pix_tot_nxt;
        blk_tot_r <= blk_tot_nxt;
      end
    end
  end

  // Output register.
  logic                 out_changed_r, out_done_r;
  logic [PIX_TOT_W-1:0] out_pix_r;
  logic [BLK_TOT_W-1:0] out_blk_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_changed_r <= changed;
      out_done_r    <= s1_flags_r.frame_end;
      out_pix_r     <= s1_flags_r.frame_end ? pix_tot_nxt : '0;
      out_blk_r     <= s1_flags_r.frame_end ? blk_tot_nxt : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_done_r;
  assign out_tdata  = {(OUT_TDATA_W - 1 - PIX_TOT_W - BLK_TOT_W)'(0),
                       out_blk_r, out_pix_r, out_changed_r};

  // The store counts as primed once the last pixel of a frame has passed the compare stage.
  a_primed_after_frame: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_flags_r.frame_end |=> primed_r)
    else $error("store not primed after frame end");

  // No pixel of the first frame is reported as changed.
  a_first_frame_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && !primed_r |=> !out_changed_r)
    else $error("changed pixel reported before store was primed");

  // A stalled output with a full compare stage blocks new items.
  a_interlock: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_tready |-> !in_tready)
    else $error("item accepted while pipeline is full");

  // Totals only show on the frame's last result.
  a_totals_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_done_r |-> (out_pix_r == '0) && (out_blk_r == '0))
    else $error("totals present on a result that does not end a frame");

endmodule
